@@ sv/evtdec_pkg.sv @@
// evtdec_pkg: types, word type codes and constants for the event word stream decoder
// used by evtdec_front, evtdec_fifo, evtdec_back and event_camera_word_stream_decoder
package evtdec_pkg;

    localparam int TIMESTAMP_BITS_DEFAULT = 48;
    localparam int QUEUE_DEPTH            = 4;
    localparam int CFG_ADDR_W             = 3;
    localparam int CFG_DATA_W             = 32;
    localparam int TS_OUT_W               = 48;
    localparam int MASK_W                 = 12;

    localparam logic [3:0] TYPE_Y        = 4'h0;
    localparam logic [3:0] TYPE_X_SINGLE = 4'h2;
    localparam logic [3:0] TYPE_X_BASE   = 4'h3;
    localparam logic [3:0] TYPE_VECT_12  = 4'h4;
    localparam logic [3:0] TYPE_VECT_8   = 4'h5;
    localparam logic [3:0] TYPE_TIME_LOW = 4'h6;
    localparam logic [3:0] TYPE_TIME_HI  = 4'h8;
    localparam logic [3:0] TYPE_TRIGGER  = 4'hA;

    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_ENABLE = 3'd0;

    localparam logic [63:0] LOOP_SPAN      = 64'h0000_0000_0100_0000;
    localparam logic [63:0] WRAP_THRESHOLD = 64'h0000_0000_00FF_F000 - (64'd10 << 12);

    localparam logic [15:0] VECT_12_SPAN = 16'd12;
    localparam logic [15:0] VECT_8_SPAN  = 16'd8;

    typedef struct packed {
        logic                is_trigger;
        logic [MASK_W-1:0]   mask;
        logic [15:0]         x_base;
        logic [10:0]         y;
        logic                polarity;
        logic [TS_OUT_W-1:0] timestamp;
        logic                level;
        logic [3:0]          channel;
    } cmd_t;

    typedef struct packed {
        logic                is_trigger;
        logic [15:0]         pixel_x;
        logic [10:0]         pixel_y;
        logic                polarity;
        logic [TS_OUT_W-1:0] timestamp_us;
        logic                trigger_level;
        logic [3:0]          trigger_channel;
        logic                last;
    } result_t;

endpackage

@@ sv/evtdec_front.sv @@
// evtdec_front: accepts raw words, keeps the decode state and queues event commands
// depends on evtdec_pkg
module evtdec_front #(
    parameter int TIMESTAMP_BITS = evtdec_pkg::TIMESTAMP_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               trigger_enable,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        raw_word,
    input  logic               queue_full,
    output logic               push,
    output evtdec_pkg::cmd_t   push_cmd
);
    import evtdec_pkg::*;

    logic                      synced_reg, synced_next;
    logic [TIMESTAMP_BITS-1:0] time_base_reg, time_base_next;
    logic [TIMESTAMP_BITS-1:0] now_time_reg, now_time_next;
    logic [10:0]               row_reg, row_next;
    logic [15:0]               column_base_reg, column_base_next;
    logic                      vector_polarity_reg, vector_polarity_next;
    logic [23:0]               loop_count_reg, loop_count_next;

    logic                      accept;
    logic [3:0]                word_type;
    logic [11:0]               payload;
    logic [63:0]               nb_full;
    logic [TIMESTAMP_BITS-1:0] nb;
    logic [TIMESTAMP_BITS-1:0] diff;
    logic                      wrapped;
    logic [TIMESTAMP_BITS-1:0] nb_adj;
    logic [TS_OUT_W-1:0]       ts_out;

    assign in_stall  = queue_full;
    assign accept    = in_valid && !queue_full;
    assign word_type = raw_word[15:12];
    assign payload   = raw_word[11:0];

    // loop count and payload sit in disjoint bit ranges
    assign nb_full = {16'd0, loop_count_reg, payload, 12'd0};
    assign nb      = nb_full[TIMESTAMP_BITS-1:0];
    assign diff    = time_base_reg - nb;
    assign wrapped = synced_reg && (time_base_reg > nb)
                     && (64'(diff) >= WRAP_THRESHOLD);
    assign nb_adj  = wrapped ? nb + TIMESTAMP_BITS'(LOOP_SPAN) : nb;
    assign ts_out  = TS_OUT_W'(64'(now_time_reg));

    always_comb
    begin
        synced_next          = synced_reg;
        time_base_next       = time_base_reg;
        now_time_next        = now_time_reg;
        row_next             = row_reg;
        column_base_next     = column_base_reg;
        vector_polarity_next = vector_polarity_reg;
        loop_count_next      = loop_count_reg;
        push                 = 1'b0;
        push_cmd             = '0;
        push_cmd.timestamp   = ts_out;
        push_cmd.y           = row_reg;
        if (accept && (synced_reg || word_type == TYPE_TIME_HI))
        begin
            case (word_type)
                TYPE_Y:
                begin
                    row_next = payload[10:0];
                end
                TYPE_X_SINGLE:
                begin
                    push              = 1'b1;
                    push_cmd.mask     = 12'd1;
                    push_cmd.x_base   = {5'd0, payload[10:0]};
                    push_cmd.polarity = payload[11];
                end
                TYPE_X_BASE:
                begin
                    column_base_next     = {5'd0, payload[10:0]};
                    vector_polarity_next = payload[11];
                end
                TYPE_VECT_12:
                begin
                    push              = (payload != 12'd0);
                    push_cmd.mask     = payload;
                    push_cmd.x_base   = column_base_reg;
                    push_cmd.polarity = vector_polarity_reg;
                    column_base_next  = column_base_reg + VECT_12_SPAN;
                end
                TYPE_VECT_8:
                begin
                    push              = (payload[7:0] != 8'd0);
                    push_cmd.mask     = {4'd0, payload[7:0]};
                    push_cmd.x_base   = column_base_reg;
                    push_cmd.polarity = vector_polarity_reg;
                    column_base_next  = column_base_reg + VECT_8_SPAN;
                end
                TYPE_TIME_LOW:
                begin
                    now_time_next = time_base_reg + TIMESTAMP_BITS'(payload);
                end
                TYPE_TIME_HI:
                begin
                    synced_next    = 1'b1;
                    time_base_next = nb_adj;
                    now_time_next  = nb_adj;
                    if (wrapped)
                    begin
                        loop_count_next = loop_count_reg + 24'd1;
                    end
                end
                TYPE_TRIGGER:
                begin
                    push                = trigger_enable;
                    push_cmd.is_trigger = 1'b1;
                    push_cmd.mask       = 12'd1;
                    push_cmd.y          = 11'd0;
                    push_cmd.level      = payload[0];
                    push_cmd.channel    = payload[11:8];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg          <= 1'b0;
            time_base_reg       <= '0;
            now_time_reg        <= '0;
            row_reg             <= '0;
            column_base_reg     <= '0;
            vector_polarity_reg <= 1'b0;
            loop_count_reg      <= '0;
        end
        else
        begin
            synced_reg          <= synced_next;
            time_base_reg       <= time_base_next;
            now_time_reg        <= now_time_next;
            row_reg             <= row_next;
            column_base_reg     <= column_base_next;
            vector_polarity_reg <= vector_polarity_next;
            loop_count_reg      <= loop_count_next;
        end
    end

`ifndef SYNTHESIS
    // once locked to a time base the decoder never drops it
    a_synced_holds: assert property (@(posedge clk) disable iff (!rst_n)
        synced_reg |=> synced_reg)
        else $error("sync lost");

    // nothing is queued before the first time-high word
    a_no_push_unsynced: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !synced_reg) |-> 1'b0)
        else $error("push before sync");
`endif

endmodule

@@ sv/evtdec_fifo.sv @@
// evtdec_fifo: short command queue between decode front and expansion back
// depends on evtdec_pkg
module evtdec_fifo #(
    parameter int DEPTH = evtdec_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  evtdec_pkg::cmd_t push_cmd,
    output logic             full,
    input  logic             pop,
    output evtdec_pkg::cmd_t pop_cmd,
    output logic             not_empty
);
    import evtdec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue underflow");
`endif

endmodule

@@ sv/evtdec_back.sv @@
// evtdec_back: expands queued commands into result beats, one per set mask bit
// depends on evtdec_pkg
module evtdec_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_avail,
    input  evtdec_pkg::cmd_t    cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output evtdec_pkg::result_t result
);
    import evtdec_pkg::*;

    cmd_t              cur_reg, cur_next;
    logic              cur_valid_reg, cur_valid_next;
    logic              out_valid_reg, out_valid_next;
    result_t           result_reg, result_next;

    logic              advance;
    logic [MASK_W-1:0] low_bit;
    logic [MASK_W-1:0] rest;
    logic [3:0]        low_idx;
    logic              last_bit;

    assign low_bit  = cur_reg.mask & (~cur_reg.mask + MASK_W'(1));
    assign rest     = cur_reg.mask & ~low_bit;
    assign last_bit = (rest == '0);
    assign advance  = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign pop      = cmd_avail && (!cur_valid_reg || (advance && last_bit));

    always_comb
    begin
        low_idx = 4'd0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = 4'(i);
            end
        end
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next              = 1'b1;
            result_next.is_trigger      = cur_reg.is_trigger;
            result_next.pixel_x         = cur_reg.x_base + {12'd0, low_idx};
            result_next.pixel_y         = cur_reg.y;
            result_next.polarity        = cur_reg.polarity;
            result_next.timestamp_us    = cur_reg.timestamp;
            result_next.trigger_level   = cur_reg.level;
            result_next.trigger_channel = cur_reg.channel;
            result_next.last            = last_bit;
            cur_next.mask               = rest;
            if (last_bit)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop)
        begin
            cur_next       = cmd;
            cur_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // an active command always has at least one beat left
    a_cur_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.mask != '0))
        else $error("empty active command");

    // a beat that is stalled keeps its contents
    a_beat_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(result_reg)))
        else $error("stalled beat changed");
`endif

endmodule

@@ sv/event_camera_word_stream_decoder.sv @@
// event_camera_word_stream_decoder: raw 16-bit event word decoder, top level
// path: an event word passes the command queue, the current command and the result registers
// throughput: one word per cycle in unless in_stall, one beat per cycle out unless out_stall;
// a vector word gives one beat per set mask bit, the 4-entry command queue absorbs bursts
// reset: asynchronous, clears decode state, queue and trigger_enable; no clearing pass
module event_camera_word_stream_decoder #(
    parameter int TIMESTAMP_BITS = evtdec_pkg::TIMESTAMP_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [evtdec_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [evtdec_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [evtdec_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [15:0]                            raw_word,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   is_trigger,
    output logic [15:0]                            pixel_x,
    output logic [10:0]                            pixel_y,
    output logic                                   polarity,
    output logic [evtdec_pkg::TS_OUT_W-1:0]        timestamp_us,
    output logic                                   trigger_level,
    output logic [3:0]                             trigger_channel,
    output logic                                   last
);
    import evtdec_pkg::*;

    logic    trigger_enable_reg, trigger_enable_next;
    logic    cfg_write;
    logic    push;
    cmd_t    push_cmd;
    logic    queue_full;
    logic    pop;
    cmd_t    pop_cmd;
    logic    queue_avail;
    result_t result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[CFG_ADDR_W-1] == REG_TRIGGER_ENABLE[CFG_ADDR_W-1])
                       ? {{(CFG_DATA_W-1){1'b0}}, trigger_enable_reg} : '0;

    always_comb
    begin
        trigger_enable_next = trigger_enable_reg;
        if (cfg_write && paddr[CFG_ADDR_W-1] == REG_TRIGGER_ENABLE[CFG_ADDR_W-1])
        begin
            trigger_enable_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_enable_reg <= 1'b0;
        end
        else
        begin
            trigger_enable_reg <= trigger_enable_next;
        end
    end

    evtdec_front #(
        .TIMESTAMP_BITS (TIMESTAMP_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .trigger_enable (trigger_enable_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .raw_word       (raw_word),
        .queue_full     (queue_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    evtdec_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .not_empty (queue_avail)
    );

    evtdec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (queue_avail),
        .cmd       (pop_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign is_trigger      = result.is_trigger;
    assign pixel_x         = result.pixel_x;
    assign pixel_y         = result.pixel_y;
    assign polarity        = result.polarity;
    assign timestamp_us    = result.timestamp_us;
    assign trigger_level   = result.trigger_level;
    assign trigger_channel = result.trigger_channel;
    assign last            = result.last;

endmodule
